// ----- hdl/sspq_pkg.sv -----
`timescale 1ns / 1ps

package sspq_pkg;

    // number of cells in the chain
    localparam int unsigned DEPTH = 16;
    // width of the occupancy counter, able to hold DEPTH itself
    localparam int unsigned CNT_W = $clog2(DEPTH + 1);

    localparam int unsigned ID_W  = 16;
    localparam int unsigned PRI_W = 8;
    localparam int unsigned OUT_CNT_W = 5;

    // operation codes
    localparam logic OP_PUSH = 1'b0;
    localparam logic OP_POP  = 1'b1;

    // priority reported by a pop on an empty queue
    localparam logic [PRI_W-1:0] EMPTY_POP_PRI = 8'd1;

    typedef enum logic [1:0] {
        ST_PUSHED      = 2'd0,
        ST_POPPED      = 2'd1,
        ST_EMPTY_POP   = 2'd2,
        ST_FULL_REJECT = 2'd3
    } status_t;

    // contents of one cell as seen by its neighbors
    typedef struct packed {
        logic             valid;
        logic [ID_W-1:0]  id;
        logic [PRI_W-1:0] pri;
    } cell_data_t;

    // command broadcast to every cell
    typedef struct packed {
        logic             push_en;
        logic             pop_en;
        logic [ID_W-1:0]  new_id;
        logic [PRI_W-1:0] new_pri;
    } cell_cmd_t;

endpackage

// ----- hdl/sspq_cell.sv -----
`timescale 1ns / 1ps

module sspq_cell (
    input  logic                aclk,
    input  logic                aresetn,
    input  sspq_pkg::cell_cmd_t cmd,
    input  sspq_pkg::cell_data_t left_data,
    input  logic                left_behind,
    input  sspq_pkg::cell_data_t right_data,
    output sspq_pkg::cell_data_t data,
    output logic                behind
);

    sspq_pkg::cell_data_t data_reg;
    sspq_pkg::cell_data_t data_next;

    // new entry goes behind this one when it holds equal or higher priority
    assign behind = data_reg.valid && (data_reg.pri >= cmd.new_pri);
    assign data   = data_reg;

    // keep, shift down on push, take new entry, or shift up on pop
    always_comb begin
        data_next = data_reg;
        if (cmd.push_en) begin
            if (!left_behind) begin
                data_next = left_data;
            end else if (!behind) begin
                data_next.valid = 1'b1;
                data_next.id    = cmd.new_id;
                data_next.pri   = cmd.new_pri;
            end
        end else if (cmd.pop_en) begin
            data_next = right_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            data_reg.valid <= 1'b0;
        end else begin
            data_reg.valid <= data_next.valid;
        end
        data_reg.id  <= data_next.id;
        data_reg.pri <= data_next.pri;
    end

endmodule

// ----- hdl/stable_sorted_priority_queue_core.sv -----
`timescale 1ns / 1ps

// Stable sorted priority queue: a chain of DEPTH cells holds entries in
// descending priority, the head in cell 0. Each beat is a push or a pop; a
// push lands behind every stored entry of equal or higher priority, so equal
// priorities leave in arrival order. One beat is taken per clock: all cells
// compare against the new priority at once and shift by one place in the
// cycle the beat is accepted, and the result beat appears in the next cycle
// from the output register. The input is stalled only while a result waits
// and m_ready is low. A push to a full queue is rejected with a status; a pop
// on an empty queue returns id 0, priority 1 and an empty status.
module stable_sorted_priority_queue_core (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic        s_operation,
    input  logic [15:0] s_incident_id,
    input  logic [7:0]  s_incident_priority,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_popped_id,
    output logic [7:0]  m_popped_priority,
    output logic [1:0]  m_status,
    output logic        m_now_empty,
    output logic [4:0]  m_entry_count
);

    localparam int unsigned DEPTH = sspq_pkg::DEPTH;
    localparam int unsigned CNT_W = sspq_pkg::CNT_W;

    sspq_pkg::cell_cmd_t  cmd;
    sspq_pkg::cell_data_t cell_q [DEPTH];
    logic [DEPTH-1:0]     behind;
    logic [DEPTH-1:0]     valid_vec;

    logic [CNT_W-1:0]     count_reg;
    logic [CNT_W-1:0]     count_next;
    logic                 s_fire;
    logic                 full;
    logic                 empty;

    logic                 m_valid_reg;
    logic [15:0]          m_popped_id_reg;
    logic [15:0]          m_popped_id_next;
    logic [7:0]           m_popped_priority_reg;
    logic [7:0]           m_popped_priority_next;
    sspq_pkg::status_t    m_status_reg;
    sspq_pkg::status_t    m_status_next;
    logic                 m_now_empty_reg;
    logic [4:0]           m_entry_count_reg;

    assign s_ready = !m_valid_reg || m_ready;
    assign s_fire  = s_valid && s_ready;
    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);

    // command to the chain
    assign cmd.push_en = s_fire && (s_operation == sspq_pkg::OP_PUSH) && !full;
    assign cmd.pop_en  = s_fire && (s_operation == sspq_pkg::OP_POP) && !empty;
    assign cmd.new_id  = s_incident_id;
    assign cmd.new_pri = s_incident_priority;

    // cell chain
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
        sspq_pkg::cell_data_t left_d;
        sspq_pkg::cell_data_t right_d;
        logic                 left_b;

        if (i == 0) begin : g_first
            assign left_d = '0;
            assign left_b = 1'b1;
        end else begin : g_mid
            assign left_d = cell_q[i-1];
            assign left_b = behind[i-1];
        end

        if (i == DEPTH - 1) begin : g_last
            assign right_d = '0;
        end else begin : g_inner
            assign right_d = cell_q[i+1];
        end

        sspq_cell u_cell (
            .aclk       (aclk),
            .aresetn    (aresetn),
            .cmd        (cmd),
            .left_data  (left_d),
            .left_behind(left_b),
            .right_data (right_d),
            .data       (cell_q[i]),
            .behind     (behind[i])
        );

        assign valid_vec[i] = cell_q[i].valid;
    end

    // occupancy and result
    always_comb begin
        count_next             = count_reg;
        m_popped_id_next       = '0;
        m_popped_priority_next = '0;
        m_status_next          = sspq_pkg::ST_PUSHED;
        if (s_operation == sspq_pkg::OP_PUSH) begin
            if (full) begin
                m_status_next = sspq_pkg::ST_FULL_REJECT;
            end else begin
                count_next = count_reg + CNT_W'(1);
            end
        end else begin
            if (empty) begin
                m_status_next          = sspq_pkg::ST_EMPTY_POP;
                m_popped_priority_next = sspq_pkg::EMPTY_POP_PRI;
            end else begin
                m_status_next          = sspq_pkg::ST_POPPED;
                m_popped_id_next       = cell_q[0].id;
                m_popped_priority_next = cell_q[0].pri;
                count_next             = count_reg - CNT_W'(1);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (s_fire) begin
                count_reg   <= count_next;
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
        if (s_fire) begin
            m_popped_id_reg       <= m_popped_id_next;
            m_popped_priority_reg <= m_popped_priority_next;
            m_status_reg          <= m_status_next;
            m_now_empty_reg       <= (count_next == '0);
            m_entry_count_reg     <= 5'(count_next);
        end
    end

    assign m_valid           = m_valid_reg;
    assign m_popped_id       = m_popped_id_reg;
    assign m_popped_priority = m_popped_priority_reg;
    assign m_status          = m_status_reg;
    assign m_now_empty       = m_now_empty_reg;
    assign m_entry_count     = m_entry_count_reg;

    // checks
    logic [DEPTH-1:0] valid_inc;
    assign valid_inc = valid_vec + {{(DEPTH-1){1'b0}}, 1'b1};

    a_count_matches_cells: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg == CNT_W'($countones(valid_vec)))
        else $error("occupancy does not match occupied cells");

    a_cells_packed: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_inc & valid_vec) == '0)
        else $error("occupied cells are not a prefix of the chain");

    a_full_push_holds: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation == sspq_pkg::OP_PUSH && full) |=> $stable(count_reg))
        else $error("rejected push changed occupancy");

    a_empty_pop_status: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_operation == sspq_pkg::OP_POP && empty)
            |=> (m_status_reg == sspq_pkg::ST_EMPTY_POP && m_now_empty))
        else $error("pop on empty queue reported wrong result");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps

module testbench;

    localparam int unsigned CYCLE_LIMIT   = 400000;
    localparam int unsigned RANDOM_BEATS  = 1450;
    localparam int unsigned CALM_TAIL     = 200;
    localparam int unsigned LONG_HOLD_AT  = 700;
    localparam int unsigned LONG_HOLD_LEN = 120;

    // one input beat, with a flag that makes the sender wait for all results first
    typedef struct {
        logic                       op;
        logic [sspq_pkg::ID_W-1:0]  id;
        logic [sspq_pkg::PRI_W-1:0] pri;
        bit                         drain;
    } queue_cmd_t;

    // one result beat as predicted
    typedef struct {
        logic [sspq_pkg::ID_W-1:0]      id;
        logic [sspq_pkg::PRI_W-1:0]     pri;
        sspq_pkg::status_t              status;
        logic                           now_empty;
        logic [sspq_pkg::OUT_CNT_W-1:0] count;
    } queue_result_t;

    logic        aclk = 1'b0;
    logic        aresetn = 1'b0;
    logic        s_valid = 1'b0;
    logic        s_ready;
    logic        s_operation = sspq_pkg::OP_PUSH;
    logic [15:0] s_incident_id = '0;
    logic [7:0]  s_incident_priority = '0;
    logic        m_valid;
    logic        m_ready = 1'b0;
    logic [15:0] m_popped_id;
    logic [7:0]  m_popped_priority;
    logic [1:0]  m_status;
    logic        m_now_empty;
    logic [4:0]  m_entry_count;

    queue_cmd_t    pending_beats[$];
    queue_result_t expected_results[$];
    queue_cmd_t    cur_beat;

    // shadow copy of the sorted store
    logic [sspq_pkg::ID_W-1:0]  shadow_ids[sspq_pkg::DEPTH];
    logic [sspq_pkg::PRI_W-1:0] shadow_pris[sspq_pkg::DEPTH];
    int unsigned                shadow_count = 0;

    int unsigned n_items = 0;
    int unsigned sent_count = 0;
    int unsigned recv_count = 0;
    int unsigned tx_gap = 0;
    int unsigned rx_stall = 0;
    int unsigned long_hold = 0;
    bit          long_hold_done = 1'b0;
    int unsigned error_count = 0;
    int unsigned cycle_count = 0;

    stable_sorted_priority_queue_core u_top (
        .aclk                (aclk),
        .aresetn             (aresetn),
        .s_valid             (s_valid),
        .s_ready             (s_ready),
        .s_operation         (s_operation),
        .s_incident_id       (s_incident_id),
        .s_incident_priority (s_incident_priority),
        .m_valid             (m_valid),
        .m_ready             (m_ready),
        .m_popped_id         (m_popped_id),
        .m_popped_priority   (m_popped_priority),
        .m_status            (m_status),
        .m_now_empty         (m_now_empty),
        .m_entry_count       (m_entry_count)
    );

    // clock
    always #5 aclk = ~aclk;

    // reset at the start, once
    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
    end

    // apply one accepted beat to the shadow store and return the result it yields
    function automatic queue_result_t apply_to_shadow_queue(queue_cmd_t cmd);
        queue_result_t res;
        int unsigned   pos;
        res.id  = '0;
        res.pri = '0;
        if (cmd.op == sspq_pkg::OP_PUSH) begin
            if (shadow_count >= sspq_pkg::DEPTH) begin
                res.status = sspq_pkg::ST_FULL_REJECT;
            end else begin
                // new entry goes behind all entries of equal or higher priority
                pos = 0;
                while (pos < shadow_count && shadow_pris[pos] >= cmd.pri)
                    pos++;
                for (int i = shadow_count; i > pos; i--) begin
                    shadow_ids[i]  = shadow_ids[i-1];
                    shadow_pris[i] = shadow_pris[i-1];
                end
                shadow_ids[pos]  = cmd.id;
                shadow_pris[pos] = cmd.pri;
                shadow_count++;
                res.status = sspq_pkg::ST_PUSHED;
            end
        end else if (shadow_count == 0) begin
            res.pri    = sspq_pkg::EMPTY_POP_PRI;
            res.status = sspq_pkg::ST_EMPTY_POP;
        end else begin
            // take the head, shift the rest up
            res.id  = shadow_ids[0];
            res.pri = shadow_pris[0];
            for (int i = 1; i < shadow_count; i++) begin
                shadow_ids[i-1]  = shadow_ids[i];
                shadow_pris[i-1] = shadow_pris[i];
            end
            shadow_count--;
            res.status = sspq_pkg::ST_POPPED;
        end
        res.now_empty = (shadow_count == 0);
        res.count     = shadow_count[sspq_pkg::OUT_CNT_W-1:0];
        return res;
    endfunction

    task automatic add_beat(logic op, logic [sspq_pkg::ID_W-1:0] id,
                            logic [sspq_pkg::PRI_W-1:0] pri);
        queue_cmd_t cmd;
        cmd.op    = op;
        cmd.id    = id;
        cmd.pri   = pri;
        cmd.drain = 1'b0;
        pending_beats.insert(pending_beats.size(), cmd);
    endtask

    // stimulus and end of run
    initial begin
        int unsigned seg_len;
        int unsigned push_pct;
        int unsigned pri_mode;
        int unsigned base_pri;
        int unsigned n_rand;
        logic        op;
        logic [15:0] id;
        logic [7:0]  pri;

        // directed: empty pop, field extremes, equal priorities, fill to full, reject
        add_beat(sspq_pkg::OP_POP, 16'h0000, 8'h00);
        add_beat(sspq_pkg::OP_PUSH, 16'hFFFF, 8'hFF);
        add_beat(sspq_pkg::OP_PUSH, 16'h0000, 8'h00);
        add_beat(sspq_pkg::OP_PUSH, 16'h1234, 8'hFF);
        add_beat(sspq_pkg::OP_PUSH, 16'h0005, 8'h80);
        add_beat(sspq_pkg::OP_POP, 16'hFFFF, 8'hFF);
        add_beat(sspq_pkg::OP_POP, 16'h0000, 8'h00);
        for (int k = 0; k < 14; k++)
            add_beat(sspq_pkg::OP_PUSH, 16'(16'h0100 + k), 8'((k % 4) * 85));
        add_beat(sspq_pkg::OP_PUSH, 16'hAAAA, 8'hC8);
        add_beat(sspq_pkg::OP_POP, 16'h5555, 8'h37);

        // random: segments biased toward filling, mixing or draining
        n_rand = 0;
        while (n_rand < RANDOM_BEATS) begin
            seg_len  = $urandom_range(10, 60);
            case ($urandom_range(0, 2))
                0: push_pct = 85;
                1: push_pct = 50;
                default: push_pct = 15;
            endcase
            pri_mode = $urandom_range(0, 3);
            base_pri = $urandom_range(0, 252);
            for (int k = 0; k < seg_len && n_rand < RANDOM_BEATS; k++) begin
                op = ($urandom_range(0, 99) < push_pct) ? sspq_pkg::OP_PUSH : sspq_pkg::OP_POP;
                case ($urandom_range(0, 9))
                    0: id = 16'h0000;
                    1: id = 16'hFFFF;
                    default: id = 16'($urandom_range(0, 65535));
                endcase
                case (pri_mode)
                    // narrow band: many equal priorities
                    1: pri = 8'(base_pri + $urandom_range(0, 3));
                    2: begin
                        case ($urandom_range(0, 3))
                            0: pri = 8'd0;
                            1: pri = 8'd1;
                            2: pri = 8'd254;
                            default: pri = 8'd255;
                        endcase
                    end
                    default: pri = 8'($urandom_range(0, 255));
                endcase
                add_beat(op, id, pri);
                n_rand++;
            end
        end
        // sender waits for every result at these points
        pending_beats[400].drain  = 1'b1;
        pending_beats[1100].drain = 1'b1;
        n_items = pending_beats.size();

        wait (aresetn);
        while (pending_beats.size() > 0 || s_valid || expected_results.size() > 0)
            @(posedge aclk);
        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

    // driver: offer beats, predict on acceptance
    always @(posedge aclk) begin
        queue_result_t pred;
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                pred = apply_to_shadow_queue(cur_beat);
                expected_results.insert(expected_results.size(), pred);
                sent_count++;
                if (sent_count + CALM_TAIL < n_items && (sent_count / 150) % 3 != 2 &&
                    $urandom_range(0, 7) == 0)
                    tx_gap = $urandom_range(1, 18);
            end
            // next beat may go out once the current one is gone
            if (!s_valid || s_ready) begin
                if (tx_gap > 0) begin
                    tx_gap--;
                    s_valid <= 1'b0;
                end else if (pending_beats.size() > 0 &&
                             !(pending_beats[0].drain && expected_results.size() > 0)) begin
                    cur_beat = pending_beats.pop_front();
                    s_valid             <= 1'b1;
                    s_operation         <= cur_beat.op;
                    s_incident_id       <= cur_beat.id;
                    s_incident_priority <= cur_beat.pri;
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // monitor: compare each result beat with the oldest prediction
    always @(posedge aclk) begin
        queue_result_t exp_res;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                if (expected_results.size() == 0) begin
                    $error("result beat with no prediction pending");
                    error_count++;
                end else begin
                    exp_res = expected_results.pop_front();
                    if (m_popped_id !== exp_res.id) begin
                        $error("popped_id: expected %0d, actual %0d", exp_res.id, m_popped_id);
                        error_count++;
                    end
                    if (m_popped_priority !== exp_res.pri) begin
                        $error("popped_priority: expected %0d, actual %0d",
                               exp_res.pri, m_popped_priority);
                        error_count++;
                    end
                    if (m_status !== exp_res.status) begin
                        $error("status: expected %0d, actual %0d", exp_res.status, m_status);
                        error_count++;
                    end
                    if (m_now_empty !== exp_res.now_empty) begin
                        $error("now_empty: expected %0d, actual %0d",
                               exp_res.now_empty, m_now_empty);
                        error_count++;
                    end
                    if (m_entry_count !== exp_res.count) begin
                        $error("entry_count: expected %0d, actual %0d",
                               exp_res.count, m_entry_count);
                        error_count++;
                    end
                end
                recv_count++;
                // one long hold-off so the block backs up and stalls its input
                if (recv_count == LONG_HOLD_AT && !long_hold_done) begin
                    long_hold      = LONG_HOLD_LEN;
                    long_hold_done = 1'b1;
                end
            end
            if (long_hold > 0) begin
                long_hold--;
                m_ready <= 1'b0;
            end else if (rx_stall > 0) begin
                rx_stall--;
                m_ready <= 1'b0;
            end else if (recv_count + CALM_TAIL < n_items && (recv_count / 120) % 3 != 2 &&
                         $urandom_range(0, 7) == 0) begin
                rx_stall = $urandom_range(0, 17);
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // watchdog
    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

endmodule
